@@ rtl/sms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the six-axis motion shaper.
// Used by every module of the block; depends on nothing.
package sms_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_UNUSED = 2'd3;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DRAG   = 2'd1;
  localparam logic [1:0] MODE_CLIP   = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_CUTOFF    = 1'b1;

  localparam logic [14:0] THRESHOLD_RESET = 15'd1;
  localparam logic [14:0] CUTOFF_RESET    = 15'd3277;

  localparam int AXES = 6;

  typedef logic signed [15:0] axis_t;
  typedef logic signed [23:0] out_axis_t;

endpackage

@@ rtl/sms_sqrt.sv @@
`timescale 1ns / 1ps
// Iterative floor square root of a 32-bit value, two radicand bits per cycle.
// Depends on sms_pkg.
module sms_sqrt
  import sms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] v_r, v_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_nxt = v_r - trial[31:0];
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[15:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("root ready without a running pass");

endmodule

@@ rtl/sms_div.sv @@
`timescale 1ns / 1ps
// Restoring divider for (num * 65536) / den with num <= den, one quotient bit per cycle.
// Depends on sms_pkg.
module sms_div
  import sms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [15:0] sh_r, sh_nxt;
  logic [16:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem2;
  logic        ge;

  assign rem2 = {rem_r, sh_r[15]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num[15:1]};
      sh_nxt   = {num[0], 15'd0};
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(rem2 - {1'b0, den_r}) : rem2[15:0];
      q_nxt   = {q_r[15:0], ge};
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && den_r != 16'd0 |-> rem_r < den_r) else $error("partial remainder out of range");

endmodule

@@ rtl/six_axis_motion_shaper_unit.sv @@
`timescale 1ns / 1ps
// Top level of the six-axis motion shaper: sequencer, shared multiplier and state.
// Depends on sms_pkg, sms_sqrt and sms_div.

// A sample, button or unused item is taken without leaving the idle state, and so is a
// tick whose activity flag is clear; an active tick keeps the input closed from its
// transfer until its result is posted: the sums of squares, the two 16-step square
// roots, up to two 17-step divisions, the switching product, the scaling, the outputs
// and the posting of the result, with every product on one shared multiplier. A
// finished result waits in the output register while samples and button presses are
// still taken; a further tick waits at its end until that result has been
// transferred. No clearing pass follows reset.
module six_axis_motion_shaper_unit
  import sms_pkg::*;
#(
  parameter int QUEUE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  axis_t       in_move_x_in,
  input  axis_t       in_move_y_in,
  input  axis_t       in_move_z_in,
  input  axis_t       in_turn_x_in,
  input  axis_t       in_turn_y_in,
  input  axis_t       in_turn_z_in,
  input  logic [31:0] in_time_now,
  input  logic [1:0]  in_button_id,
  output logic        out_valid,
  input  logic        out_ready,
  output out_axis_t   out_move_x_out,
  output out_axis_t   out_move_y_out,
  output out_axis_t   out_move_z_out,
  output out_axis_t   out_turn_x_out,
  output out_axis_t   out_turn_y_out,
  output out_axis_t   out_turn_z_out,
  output logic [1:0]  out_mode
);

  localparam int CW = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_RT_GO = 4'd2;
  localparam logic [3:0] S_RT_WT = 4'd3;
  localparam logic [3:0] S_RR_GO = 4'd4;
  localparam logic [3:0] S_RR_WT = 4'd5;
  localparam logic [3:0] S_RAT   = 4'd6;
  localparam logic [3:0] S_RAT_W = 4'd7;
  localparam logic [3:0] S_SHAPE = 4'd8;
  localparam logic [3:0] S_T_WT  = 4'd9;
  localparam logic [3:0] S_FSQ   = 4'd10;
  localparam logic [3:0] S_SCALE = 4'd11;
  localparam logic [3:0] S_OMUL  = 4'd12;
  localparam logic [3:0] S_OWR   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [14:0]   thr_r, cut_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  axis_t         lat_r [AXES];
  axis_t         mv_r [AXES];
  logic          act_r, act_nxt;
  logic [31:0]   last_r, last_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   delta_r, delta_nxt;
  logic [31:0]   st_r, st_nxt, sr_r, sr_nxt;
  logic [15:0]   lt_r, lt_nxt, lr_r, lr_nxt;
  logic [16:0]   ratio_r, ratio_nxt;
  logic [15:0]   t_r, t_nxt;
  logic          usq_r, usq_nxt;
  logic [16:0]   f_r, f_nxt;
  logic          rotw_r, rotw_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic signed [48:0] p_r, p_nxt;
  out_axis_t     res_r [AXES];
  out_axis_t     outv_r [AXES];
  logic [1:0]    omode_r;
  logic          out_valid_r, out_valid_nxt;

  logic          in_fire;
  logic [2:0]    rd_idx;
  axis_t         rd_val;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic          act_smp;
  logic          sq_start, dv_start;
  logic [31:0]   sq_rad;
  logic          sq_done, dv_done;
  logic [15:0]   sq_root;
  logic [15:0]   dv_num, dv_den;
  logic [16:0]   dv_quot;
  logic [15:0]   dom, sub;
  logic [16:0]   u17;
  logic signed [50:0] pt;
  logic signed [48:0] qb, qv;
  logic signed [49:0] qn;
  out_axis_t     sat;
  logic          res_we, mv_we, lat_we, tick_copy;
  axis_t         mv_wval;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      cut_r <= CUTOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata;
        REG_CUTOFF:    cut_r <= cfg_wdata;
        default:       thr_r <= thr_r;
      endcase
    end
  end

  always_comb begin
    act_smp = 1'b0;
    if ({1'b0, (in_move_x_in < 0) ? -17'(in_move_x_in) : 17'(in_move_x_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
    if ({1'b0, (in_move_y_in < 0) ? -17'(in_move_y_in) : 17'(in_move_y_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
    if ({1'b0, (in_move_z_in < 0) ? -17'(in_move_z_in) : 17'(in_move_z_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
    if ({1'b0, (in_turn_x_in < 0) ? -17'(in_turn_x_in) : 17'(in_turn_x_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
    if ({1'b0, (in_turn_y_in < 0) ? -17'(in_turn_y_in) : 17'(in_turn_y_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
    if ({1'b0, (in_turn_z_in < 0) ? -17'(in_turn_z_in) : 17'(in_turn_z_in)} >= {3'd0, thr_r})
      act_smp = 1'b1;
  end

  assign rd_idx = (state_r == S_SCALE) ? (rotw_r ? 3'd3 : 3'd0) + idx_r : idx_r;
  assign rd_val = mv_r[rd_idx];
  assign u17    = 17'd65536 - ratio_r;
  assign dom    = (lr_r > lt_r) ? lr_r : lt_r;
  assign sub    = (lr_r > lt_r) ? lt_r : lr_r;

  always_comb begin
    mul_a = 33'(rd_val);
    mul_b = 18'(rd_val);
    case (state_r)
      S_FSQ: begin
        mul_a = usq_r ? {16'd0, u17} : {17'd0, t_r};
        mul_b = usq_r ? {1'b0, u17} : {2'b0, t_r};
      end
      S_SCALE: mul_b = {1'b0, f_r};
      S_OMUL:  mul_a = {1'b0, delta_r};
      default: mul_b = 18'(rd_val);
    endcase
  end

  assign prod = mul_a * mul_b;
  assign pt   = prod + ((prod < 0) ? 51'sd65535 : 51'sd0);

  always_comb begin
    qb = 49'sd0;
    if (p_r < 0) qb = (idx_r >= 3'd3) ? 49'sd511 : 49'sd1023;
    qv = (idx_r >= 3'd3) ? ((p_r + qb) >>> 9) : ((p_r + qb) >>> 10);
    qn = (idx_r == 3'd0 || idx_r == 3'd3) ? 50'(qv) : -50'(qv);
    if (qn > 50'sd8388607) sat = 24'sd8388607;
    else if (qn < -50'sd8388608) sat = -24'sd8388608;
    else sat = qn[23:0];
  end

  assign sq_rad = (state_r == S_RT_GO) ? st_r : sr_r;
  assign dv_num = (state_r == S_RAT) ? sub : 16'(ratio_r - {2'b0, cut_r});
  assign dv_den = (state_r == S_RAT) ? dom : 16'(17'd32768 - {2'b0, cut_r});

  sms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  sms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    last_nxt      = last_r;
    mode_nxt      = mode_r;
    delta_nxt     = delta_r;
    st_nxt        = st_r;
    sr_nxt        = sr_r;
    lt_nxt        = lt_r;
    lr_nxt        = lr_r;
    ratio_nxt     = ratio_r;
    t_nxt         = t_r;
    usq_nxt       = usq_r;
    f_nxt         = f_r;
    rotw_nxt      = rotw_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    sq_start      = 1'b0;
    dv_start      = 1'b0;
    lat_we        = 1'b0;
    tick_copy     = 1'b0;
    mv_we         = 1'b0;
    mv_wval       = pt[31:16];
    res_we        = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_SAMPLE: begin
              if (cnt_r < CNT_FULL) begin
                lat_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (act_smp && !act_r) last_nxt = in_time_now;
                act_nxt = act_smp;
              end
            end
            CMD_BUTTON: begin
              if (in_button_id == BTN_LEFT)
                mode_nxt = (mode_r != MODE_DRAG) ? MODE_DRAG : MODE_NORMAL;
              else if (in_button_id == BTN_RIGHT)
                mode_nxt = (mode_r != MODE_CLIP) ? MODE_CLIP : MODE_NORMAL;
            end
            CMD_TICK: begin
              if (cnt_r != '0) begin
                tick_copy = 1'b1;
                cnt_nxt   = '0;
              end
              if (act_r) begin
                delta_nxt = in_time_now - last_r;
                last_nxt  = in_time_now;
                st_nxt    = '0;
                sr_nxt    = '0;
                idx_nxt   = '0;
                state_nxt = S_SQ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SQ: begin
        if (idx_r < 3'd3) st_nxt = st_r + prod[31:0];
        else sr_nxt = sr_r + prod[31:0];
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) state_nxt = S_RT_GO;
      end
      S_RT_GO: begin
        sq_start  = 1'b1;
        state_nxt = S_RT_WT;
      end
      S_RT_WT: begin
        if (sq_done) begin
          lt_nxt    = sq_root;
          state_nxt = S_RR_GO;
        end
      end
      S_RR_GO: begin
        sq_start  = 1'b1;
        state_nxt = S_RR_WT;
      end
      S_RR_WT: begin
        if (sq_done) begin
          lr_nxt    = sq_root;
          state_nxt = S_RAT;
        end
      end
      S_RAT: begin
        rotw_nxt = !(lr_r > lt_r);
        idx_nxt  = '0;
        if (dom == 16'd0) begin
          f_nxt     = '0;
          state_nxt = S_SCALE;
        end else begin
          dv_start  = 1'b1;
          state_nxt = S_RAT_W;
        end
      end
      S_RAT_W: begin
        if (dv_done) begin
          ratio_nxt = dv_quot;
          state_nxt = S_SHAPE;
        end
      end
      S_SHAPE: begin
        if (ratio_r < {2'b0, cut_r}) begin
          f_nxt     = '0;
          state_nxt = S_SCALE;
        end else if (ratio_r < 17'd32768) begin
          dv_start  = 1'b1;
          usq_nxt   = 1'b0;
          state_nxt = S_T_WT;
        end else begin
          usq_nxt   = 1'b1;
          state_nxt = S_FSQ;
        end
      end
      S_T_WT: begin
        if (dv_done) begin
          t_nxt     = dv_quot[15:0];
          state_nxt = S_FSQ;
        end
      end
      S_FSQ: begin
        f_nxt     = usq_r ? 17'(17'd65536 - {1'b0, prod[31:16]}) : {1'b0, prod[31:16]};
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        mv_we   = 1'b1;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd2) begin
          idx_nxt   = '0;
          state_nxt = S_OMUL;
        end
      end
      S_OMUL: begin
        p_nxt     = prod[48:0];
        state_nxt = S_OWR;
      end
      S_OWR: begin
        res_we  = 1'b1;
        idx_nxt = idx_r + 3'd1;
        state_nxt = (idx_r == 3'd5) ? S_FIN : S_OMUL;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act_r       <= 1'b0;
      last_r      <= '0;
      mode_r      <= MODE_NORMAL;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        lat_r[i] <= '0;
        mv_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      last_r      <= last_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (lat_we) begin
        lat_r[0] <= in_move_x_in;
        lat_r[1] <= in_move_y_in;
        lat_r[2] <= in_move_z_in;
        lat_r[3] <= in_turn_x_in;
        lat_r[4] <= in_turn_y_in;
        lat_r[5] <= in_turn_z_in;
      end
      if (tick_copy) begin
        for (int i = 0; i < AXES; i++) mv_r[i] <= lat_r[i];
      end else if (mv_we) begin
        mv_r[rd_idx] <= mv_wval;
      end
    end
    delta_r <= delta_nxt;
    st_r    <= st_nxt;
    sr_r    <= sr_nxt;
    lt_r    <= lt_nxt;
    lr_r    <= lr_nxt;
    ratio_r <= ratio_nxt;
    t_r     <= t_nxt;
    usq_r   <= usq_nxt;
    f_r     <= f_nxt;
    rotw_r  <= rotw_nxt;
    idx_r   <= idx_nxt;
    p_r     <= p_nxt;
    if (res_we) res_r[idx_r] <= sat;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      for (int i = 0; i < AXES; i++) outv_r[i] <= res_r[i];
      omode_r <= mode_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_move_x_out = outv_r[0];
  assign out_move_y_out = outv_r[1];
  assign out_move_z_out = outv_r[2];
  assign out_turn_x_out = outv_r[3];
  assign out_turn_y_out = outv_r[4];
  assign out_turn_z_out = outv_r[5];
  assign out_mode       = omode_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("unread count beyond queue depth");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("input taken during a tick");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN) else $error("result without a finished tick");

  a_f_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCALE |-> f_r <= 17'd65536) else $error("switching factor above one");

endmodule

@@ dv/sms_checker.sv @@
`timescale 1ns / 1ps
// Checker for the six-axis motion shaper: predicts results from accepted inputs
// and compares each output transfer with the oldest prediction. Depends on sms_pkg.
module sms_checker
  import sms_pkg::*;
#(
  parameter int QUEUE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  axis_t       in_axes [AXES],
  input  logic [31:0] in_time_now,
  input  logic [1:0]  in_button_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_axis_t   out_axes [AXES],
  input  logic [1:0]  out_mode,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    out_axis_t [AXES-1:0] axes;
    logic [1:0]           mode;
  } motion_t;

  motion_t       shaped_q[$];
  logic [14:0]   threshold;
  logic [14:0]   cutoff;
  int unsigned   unread;
  longint        latest [AXES];
  longint        motion [AXES];
  bit            active;
  logic [31:0]   last_stamp;
  logic [1:0]    mode_now;

  assign pending_count = shaped_q.size();

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_length(int base);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += 32'(motion[base+i] * motion[base+i]);
    return root_floor(s);
  endfunction

  function automatic longint blend_gain(longint ratio);
    longint c;
    longint t;
    longint u;
    c = cutoff;
    if (ratio < c) return 0;
    if (ratio < 32768) begin
      t = ((ratio - c) << 16) / (32768 - c);
      return (t * t) >>> 16;
    end
    u = 65536 - ratio;
    return 65536 - ((u * u) >>> 16);
  endfunction

  function automatic out_axis_t clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return out_axis_t'(v);
  endfunction

  task automatic take_input();
    bit act;
    longint m;
    longint lt;
    longint lr;
    longint dom;
    longint sub;
    longint f;
    longint p;
    longint q;
    int weak_base;
    logic [31:0] delta;
    motion_t r;
    case (in_command)
      CMD_SAMPLE: begin
        if (unread < QUEUE_SLOTS - 1) begin
          act = 0;
          for (int i = 0; i < AXES; i++) begin
            latest[i] = in_axes[i];
            m = latest[i] < 0 ? -latest[i] : latest[i];
            if (m >= threshold) act = 1;
          end
          unread++;
          if (act && !active) last_stamp = in_time_now;
          active = act;
        end
      end
      CMD_BUTTON: begin
        if (in_button_id == BTN_LEFT)
          mode_now = (mode_now != MODE_DRAG) ? MODE_DRAG : MODE_NORMAL;
        else if (in_button_id == BTN_RIGHT)
          mode_now = (mode_now != MODE_CLIP) ? MODE_CLIP : MODE_NORMAL;
      end
      CMD_TICK: begin
        if (unread != 0) begin
          motion = latest;
          unread = 0;
        end
        if (active) begin
          delta = in_time_now - last_stamp;
          last_stamp = in_time_now;
          lt = vector_length(0);
          lr = vector_length(3);
          weak_base = (lr > lt) ? 0 : 3;
          dom = (lr > lt) ? lr : lt;
          sub = (lr > lt) ? lt : lr;
          f = (dom != 0) ? blend_gain((sub << 16) / dom) : 0;
          for (int i = 0; i < 3; i++)
            motion[weak_base+i] = (motion[weak_base+i] * f) / 65536;
          for (int i = 0; i < AXES; i++) begin
            p = longint'(delta) * motion[i];
            q = (i < 3) ? p / 1024 : (p * 2) / 1024;
            if (i != 0 && i != 3) q = -q;
            r.axes[i] = clamp24(q);
          end
          r.mode = mode_now;
          shaped_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic compare_result();
    motion_t e;
    if (shaped_q.size() == 0) begin
      $display("unexpected result transfer at %0t", $realtime);
      fail_count++;
      return;
    end
    e = shaped_q.pop_front();
    for (int i = 0; i < AXES; i++)
      if (out_axes[i] !== e.axes[i]) report_mismatch($sformatf("axis %0d", i), out_axes[i], e.axes[i]);
    if (out_mode !== e.mode) report_mismatch("mode", out_mode, e.mode);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THRESHOLD_RESET;
      cutoff = CUTOFF_RESET;
      unread = 0;
      for (int i = 0; i < AXES; i++) begin
        latest[i] = 0;
        motion[i] = 0;
      end
      active = 0;
      last_stamp = 0;
      mode_now = MODE_NORMAL;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) threshold = cfg_wdata;
        else cutoff = cfg_wdata;
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) take_input();
    end
  end

endmodule

@@ dv/six_axis_motion_shaper_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the six-axis motion shaper: drives directed and random transfers
// through several register settings, gives the verdict. Uses sms_pkg, sms_checker, the DUT.
module six_axis_motion_shaper_unit_tb;
  import sms_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_index = REG_THRESHOLD;
  logic [14:0] cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_SAMPLE;
  axis_t       in_axes [AXES];
  logic [31:0] in_time_now = 0;
  logic [1:0]  in_button_id = 0;
  logic        out_valid;
  logic        out_ready = 0;
  out_axis_t   out_axes [AXES];
  logic [1:0]  out_mode;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  logic [31:0] clock_now = 0;

  initial for (int i = 0; i < AXES; i++) in_axes[i] = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  six_axis_motion_shaper_unit dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_ready, .in_command,
    .in_move_x_in(in_axes[0]), .in_move_y_in(in_axes[1]), .in_move_z_in(in_axes[2]),
    .in_turn_x_in(in_axes[3]), .in_turn_y_in(in_axes[4]), .in_turn_z_in(in_axes[5]),
    .in_time_now, .in_button_id, .out_valid, .out_ready,
    .out_move_x_out(out_axes[0]), .out_move_y_out(out_axes[1]),
    .out_move_z_out(out_axes[2]), .out_turn_x_out(out_axes[3]),
    .out_turn_y_out(out_axes[4]), .out_turn_z_out(out_axes[5]), .out_mode
  );

  sms_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_ready, .in_command,
    .in_axes, .in_time_now, .in_button_id, .out_valid, .out_ready, .out_axes,
    .out_mode, .fail_count, .pending_count
  );

  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [31:0] stamp, logic [1:0] btn,
                      logic [95:0] axes);
    @(negedge clk);
    in_command <= cmd;
    in_time_now <= stamp;
    in_button_id <= btn;
    for (int i = 0; i < AXES; i++) in_axes[i] <= axes[i*16 +: 16];
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic logic [95:0] fill(logic [15:0] v);
    return {6{v}};
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic sample_now(logic [95:0] axes);
    clock_now += $urandom_range(1, 30);
    send(CMD_SAMPLE, clock_now, 0, axes);
  endtask

  task automatic tick_now();
    clock_now += $urandom_range(1, 600);
    send(CMD_TICK, clock_now, 0, 0);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    while (pending_count != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count);
    logic [95:0] a;
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      case ($urandom_range(0, 9))
        0: send(CMD_BUTTON, clock_now, 2'($urandom), 96'($urandom));
        1: send(CMD_UNUSED, 32'($urandom), 2'($urandom), {$urandom, $urandom, $urandom});
        2, 3, 4: tick_now();
        9: if ($urandom_range(0, 7) == 0) begin
          clock_now = 32'hFFFFFF00 + $urandom_range(0, 200);
          sample_now(fill(16'h1000));
        end else begin
          sample_now({$urandom, $urandom, $urandom});
        end
        default: begin
          for (int i = 0; i < AXES; i++) a[i*16 +: 16] = rand_axis();
          sample_now(a);
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    tick_now();
    sample_now(fill(16'h7FFF));
    tick_now();
    sample_now(fill(16'h8000));
    tick_now();
    sample_now({16'd0, 16'd0, 16'd0, 16'h1000, 16'd0, 16'd0});
    tick_now();
    sample_now({16'd0, 16'd0, 16'h0800, 16'd0, 16'd0, 16'h1000});
    tick_now();
    sample_now(fill(16'd0));
    tick_now();
    send(CMD_BUTTON, clock_now, BTN_LEFT, 0);
    send(CMD_BUTTON, clock_now, BTN_RIGHT, 0);
    send(CMD_BUTTON, clock_now, BTN_UNUSED, 0);
    send(CMD_BUTTON, clock_now, BTN_RIGHT, 0);
    send(CMD_UNUSED, 32'hFFFFFFFF, BTN_UNUSED, {96{1'b1}});
    for (int i = 0; i < 34; i++) sample_now(fill(16'h0100 + i));
    tick_now();
    clock_now = 32'hFFFFFFF0;
    sample_now(fill(16'h2000));
    clock_now = 32'h00000010;
    send(CMD_TICK, clock_now, 0, 0);

    random_phase(150);

    write_reg(REG_THRESHOLD, 15'h7FFF);
    write_reg(REG_CUTOFF, 15'd0);
    random_phase(100);

    write_reg(REG_THRESHOLD, 15'd0);
    write_reg(REG_CUTOFF, 15'h7FFF);
    random_phase(100);

    write_reg(REG_THRESHOLD, 15'd200);
    write_reg(REG_CUTOFF, 15'd16000);
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_phase(80);
    join

    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
    write_reg(REG_CUTOFF, CUTOFF_RESET);
    random_phase(150);

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
